FILE: hdl/smsf_pkg.sv
// types, constants and helper function for the minimum seam finder
// no dependencies
package smsf_pkg;

   localparam int ENERGY_W     = 8;
   localparam int ROW_W        = 6;
   localparam int COL_W        = 8;
   localparam int COST_W       = 14;
   localparam int WIDTH_CFG_W  = 9;
   localparam int HEIGHT_CFG_W = 7;
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = 9;

   typedef logic [CSR_IDX_W-1:0] csr_index_type;
   typedef logic [COST_W-1:0]    cost_type;
   typedef logic [1:0]           sel_type;

   localparam csr_index_type REG_IMAGE_WIDTH  = 1'd0;
   localparam csr_index_type REG_IMAGE_HEIGHT = 1'd1;

   localparam logic [WIDTH_CFG_W-1:0]  WIDTH_RESET  = 9'd256;
   localparam logic [HEIGHT_CFG_W-1:0] HEIGHT_RESET = 7'd64;

   localparam sel_type SEL_LEFT   = 2'd0;
   localparam sel_type SEL_CENTER = 2'd1;
   localparam sel_type SEL_RIGHT  = 2'd2;

   // cheapest of up to three neighbors, left then center then right on ties
   function automatic sel_type best_sel(input cost_type left, input cost_type center,
                                        input cost_type right, input logic has_left,
                                        input logic has_right);
      sel_type  sel;
      cost_type bv;
      sel = SEL_CENTER;
      bv  = center;
      if (has_left && (left <= bv)) begin
         sel = SEL_LEFT;
         bv  = left;
      end
      if (has_right && (right < bv)) begin
         sel = SEL_RIGHT;
      end
      return sel;
   endfunction

endpackage

FILE: hdl/smsf_req_if.sv
// pixel energy channel: valid, ready and energy payload
// depends on smsf_pkg
interface smsf_req_if import smsf_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ENERGY_W-1:0] energy;

   modport source (output valid, output energy, input ready);
   modport sink   (input valid, input energy, output ready);
endinterface

FILE: hdl/smsf_rsp_if.sv
// seam result channel: valid, ready and seam entry payload
// depends on smsf_pkg
interface smsf_rsp_if import smsf_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [ROW_W-1:0] seam_row;
   logic [COL_W-1:0] seam_column;
   logic             seam_last;

   modport source (output valid, output seam_row, output seam_column, output seam_last,
                   input ready);
   modport sink   (input valid, input seam_row, input seam_column, input seam_last,
                   output ready);
endinterface

FILE: hdl/smsf_cost_ram.sv
// cumulative cost memory: one write port, two registered read ports
// same-cycle write data is forwarded to a read of the same entry; depends on smsf_pkg
module smsf_cost_ram import smsf_pkg::*; #(
   parameter int DEPTH = 16384,
   parameter int AW    = 14
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  cost_type      wr_data,
   input  logic [AW-1:0] rd0_addr,
   input  logic [AW-1:0] rd1_addr,
   output cost_type      rd0_data,
   output cost_type      rd1_data
);

   cost_type mem [DEPTH];
   cost_type q0_ff;
   cost_type q1_ff;
   cost_type fwd_ff;
   logic     fw0_ff;
   logic     fw1_ff;
   logic     fw0_in;
   logic     fw1_in;

   assign fw0_in = wr_en && (rd0_addr == wr_addr);
   assign fw1_in = wr_en && (rd1_addr == wr_addr);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      q0_ff  <= mem[rd0_addr];
      q1_ff  <= mem[rd1_addr];
      fwd_ff <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fw0_ff <= 1'b0;
         fw1_ff <= 1'b0;
      end else begin
         fw0_ff <= fw0_in;
         fw1_ff <= fw1_in;
      end
   end

   assign rd0_data = fw0_ff ? fwd_ff : q0_ff;
   assign rd1_data = fw1_ff ? fwd_ff : q1_ff;

endmodule

FILE: hdl/seam_carving_min_seam_finder.sv
// vertical minimum seam finder: pixels stream in at one per cycle while in the fill state
// (none are taken during the seam search); after the frame's last pixel the bottom row is
// scanned, the backtrack walks each row up through states BK_A, BK_B and BK_C (three cost
// reads on the two-port cost memory), and each seam entry is read, then loaded into the
// output register, waiting while the output is stalled. reset clears control state and loads
// width 256 / height 64; cost and seam memories are not cleared.
module seam_carving_min_seam_finder import smsf_pkg::*; #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   smsf_req_if.sink              req_ch,
   smsf_rsp_if.source            rsp_ch,
   input  logic                  csr_wr_en,
   input  csr_index_type         csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int XW     = $clog2(MAX_WIDTH);
   localparam int YW     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int WW     = $clog2(MAX_WIDTH + 1);
   localparam int HW     = $clog2(MAX_HEIGHT + 1);
   localparam int CDEPTH = MAX_HEIGHT * (2 ** XW);
   localparam int CAW    = $clog2(CDEPTH);

   localparam logic [2:0] ST_FILL     = 3'd0;
   localparam logic [2:0] ST_FIND     = 3'd1;
   localparam logic [2:0] ST_FIND_END = 3'd2;
   localparam logic [2:0] ST_BK_A     = 3'd3;
   localparam logic [2:0] ST_BK_B     = 3'd4;
   localparam logic [2:0] ST_BK_C     = 3'd5;
   localparam logic [2:0] ST_EM_RD    = 3'd6;
   localparam logic [2:0] ST_EM_LD    = 3'd7;

   // configuration and control
   logic [WIDTH_CFG_W-1:0]  width_ff, width_in;
   logic [HEIGHT_CFG_W-1:0] height_ff, height_in;
   logic [2:0]              state_ff, state_in;
   logic [XW-1:0]           col_ff, col_in;
   logic [YW-1:0]           row_ff, row_in;

   // cost update stage
   logic                b_v_ff, b_v_in;
   logic [ENERGY_W-1:0] b_e_ff, b_e_in;
   logic [XW-1:0]       b_col_ff, b_col_in;
   logic [YW-1:0]       b_row_ff, b_row_in;
   cost_type            lft_ff, lft_in;
   cost_type            ctr_ff, ctr_in;

   // bottom row scan
   logic [XW-1:0] scan_ff, scan_in;
   logic          fv_ff, fv_in;
   logic [XW-1:0] fcol_ff, fcol_in;
   cost_type      best_cost_ff, best_cost_in;
   logic [XW-1:0] best_col_ff, best_col_in;

   // backtrack
   logic [YW-1:0] bk_row_ff, bk_row_in;
   logic [XW-1:0] bk_col_ff, bk_col_in;
   cost_type      bl_ff, bl_in;
   cost_type      bc_ff, bc_in;

   // result output
   logic [YW-1:0]    em_row_ff, em_row_in;
   logic             out_v_ff, out_v_in;
   logic [ROW_W-1:0] out_row_ff, out_row_in;
   logic [COL_W-1:0] out_col_ff, out_col_in;
   logic             out_last_ff, out_last_in;

   // seam memory
   logic [XW-1:0] seam_mem [MAX_HEIGHT];
   logic [XW-1:0] seam_q_ff;
   logic          seam_we;
   logic [YW-1:0] seam_waddr;
   logic [XW-1:0] seam_wdata;

   // cost memory
   logic           c_we;
   logic [CAW-1:0] c_waddr;
   cost_type       c_wdata;
   logic [CAW-1:0] c_raddr0;
   logic [CAW-1:0] c_raddr1;
   cost_type       c_rd0;
   cost_type       c_rd1;

   logic [WW-1:0] eff_w;
   logic [HW-1:0] eff_h;
   logic [YW-1:0] h_last;
   logic [XW-1:0] w_last;
   logic [YW-1:0] prev_row;
   logic [YW-1:0] bk_up;
   logic          req_acc;
   logic          last_col;
   logic          last_row;
   cost_type      b_ctr;
   sel_type       b_sel;
   cost_type      b_pick;
   cost_type      b_cost;
   logic          f_take;
   sel_type       k_sel;
   logic [XW-1:0] k_col;
   logic          em_last;
   logic          out_free;

   smsf_cost_ram #(
      .DEPTH (CDEPTH),
      .AW    (CAW)
   ) u_cost_ram (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (c_we),
      .wr_addr  (c_waddr),
      .wr_data  (c_wdata),
      .rd0_addr (c_raddr0),
      .rd1_addr (c_raddr1),
      .rd0_data (c_rd0),
      .rd1_data (c_rd1)
   );

   always_comb begin
      if (width_ff == '0) begin
         eff_w = WW'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         eff_w = WW'(MAX_WIDTH);
      end else begin
         eff_w = WW'(width_ff);
      end
      if (height_ff == '0) begin
         eff_h = HW'(1);
      end else if (32'(height_ff) > MAX_HEIGHT) begin
         eff_h = HW'(MAX_HEIGHT);
      end else begin
         eff_h = HW'(height_ff);
      end
   end

   assign h_last   = YW'(eff_h - HW'(1));
   assign w_last   = XW'(eff_w - WW'(1));
   assign prev_row = (row_ff == '0) ? '0 : row_ff - YW'(1);
   assign bk_up    = bk_row_ff - YW'(1);
   assign req_acc  = req_ch.valid && req_ch.ready;
   assign last_col = ((WW'(col_ff) + WW'(1)) == eff_w);
   assign last_row = ((HW'(row_ff) + HW'(1)) == eff_h);
   assign em_last  = ((HW'(em_row_ff) + HW'(1)) == eff_h);
   assign out_free = !out_v_ff || rsp_ch.ready;

   assign req_ch.ready       = (state_ff == ST_FILL);
   assign rsp_ch.valid       = out_v_ff;
   assign rsp_ch.seam_row    = out_row_ff;
   assign rsp_ch.seam_column = out_col_ff;
   assign rsp_ch.seam_last   = out_last_ff;

   // cost update for the pixel accepted last cycle
   always_comb begin
      b_ctr = (b_col_ff == '0) ? c_rd0 : ctr_ff;
      b_sel = best_sel(lft_ff, b_ctr, c_rd1, (b_col_ff != '0),
                       ((WW'(b_col_ff) + WW'(1)) < eff_w));
      unique case (b_sel)
         SEL_LEFT:  b_pick = lft_ff;
         SEL_RIGHT: b_pick = c_rd1;
         default:   b_pick = b_ctr;
      endcase
      if (b_row_ff == '0) begin
         b_cost = COST_W'(b_e_ff);
      end else begin
         b_cost = COST_W'(COST_W'(b_e_ff) + b_pick);
      end
   end

   assign c_we    = b_v_ff;
   assign c_waddr = CAW'({b_row_ff, b_col_ff});
   assign c_wdata = b_cost;

   // backtrack step
   always_comb begin
      k_sel = best_sel(bl_ff, bc_ff, c_rd1, (bk_col_ff != '0),
                       ((WW'(bk_col_ff) + WW'(1)) < eff_w));
      unique case (k_sel)
         SEL_LEFT:  k_col = bk_col_ff - XW'(1);
         SEL_RIGHT: k_col = bk_col_ff + XW'(1);
         default:   k_col = bk_col_ff;
      endcase
   end

   assign f_take = fv_ff && ((fcol_ff == '0) || (c_rd1 < best_cost_ff));

   always_comb begin
      c_raddr0 = CAW'({prev_row, {XW{1'b0}}});
      c_raddr1 = CAW'({prev_row, col_ff + XW'(1)});
      unique case (state_ff)
         ST_FIND: begin
            c_raddr1 = CAW'({h_last, scan_ff});
         end
         ST_BK_A: begin
            c_raddr0 = CAW'({bk_up, bk_col_ff - XW'(1)});
            c_raddr1 = CAW'({bk_up, bk_col_ff});
         end
         ST_BK_B: begin
            c_raddr1 = CAW'({bk_up, bk_col_ff + XW'(1)});
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      width_in     = width_ff;
      height_in    = height_ff;
      state_in     = state_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      b_v_in       = req_acc;
      b_e_in       = req_ch.energy;
      b_col_in     = col_ff;
      b_row_in     = row_ff;
      lft_in       = b_v_ff ? b_ctr : lft_ff;
      ctr_in       = b_v_ff ? c_rd1 : ctr_ff;
      scan_in      = scan_ff;
      fv_in        = 1'b0;
      fcol_in      = scan_ff;
      best_cost_in = f_take ? c_rd1 : best_cost_ff;
      best_col_in  = f_take ? fcol_ff : best_col_ff;
      bk_row_in    = bk_row_ff;
      bk_col_in    = bk_col_ff;
      bl_in        = bl_ff;
      bc_in        = bc_ff;
      em_row_in    = em_row_ff;
      out_v_in     = out_v_ff && !rsp_ch.ready;
      out_row_in   = out_row_ff;
      out_col_in   = out_col_ff;
      out_last_in  = out_last_ff;
      seam_we      = 1'b0;
      seam_waddr   = bk_up;
      seam_wdata   = k_col;

      unique case (state_ff)
         ST_FILL: begin
            if (req_acc) begin
               if (last_col) begin
                  col_in = '0;
                  if (last_row) begin
                     row_in   = '0;
                     scan_in  = '0;
                     state_in = ST_FIND;
                  end else begin
                     row_in = row_ff + YW'(1);
                  end
               end else begin
                  col_in = col_ff + XW'(1);
               end
            end
         end
         ST_FIND: begin
            fv_in   = 1'b1;
            scan_in = scan_ff + XW'(1);
            if (scan_ff == w_last) begin
               state_in = ST_FIND_END;
            end
         end
         ST_FIND_END: begin
            seam_we    = 1'b1;
            seam_waddr = h_last;
            seam_wdata = best_col_in;
            bk_col_in  = best_col_in;
            bk_row_in  = h_last;
            em_row_in  = '0;
            state_in   = (h_last == '0) ? ST_EM_RD : ST_BK_A;
         end
         ST_BK_A: begin
            state_in = ST_BK_B;
         end
         ST_BK_B: begin
            bl_in    = c_rd0;
            bc_in    = c_rd1;
            state_in = ST_BK_C;
         end
         ST_BK_C: begin
            seam_we   = 1'b1;
            bk_col_in = k_col;
            bk_row_in = bk_up;
            state_in  = (bk_up == '0) ? ST_EM_RD : ST_BK_A;
         end
         ST_EM_RD: begin
            state_in = ST_EM_LD;
         end
         ST_EM_LD: begin
            if (out_free) begin
               out_v_in    = 1'b1;
               out_row_in  = ROW_W'(em_row_ff);
               out_col_in  = COL_W'(seam_q_ff);
               out_last_in = em_last;
               if (em_last) begin
                  state_in = ST_FILL;
               end else begin
                  em_row_in = em_row_ff + YW'(1);
                  state_in  = ST_EM_RD;
               end
            end
         end
         default: begin
            state_in = ST_FILL;
         end
      endcase

      // a register write restarts the frame
      if (csr_wr_en) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH:  width_in  = csr_wdata[WIDTH_CFG_W-1:0];
            REG_IMAGE_HEIGHT: height_in = csr_wdata[HEIGHT_CFG_W-1:0];
            default: begin
            end
         endcase
         col_in = '0;
         row_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (seam_we) begin
         seam_mem[seam_waddr] <= seam_wdata;
      end
      seam_q_ff <= seam_mem[em_row_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         state_ff  <= ST_FILL;
         col_ff    <= '0;
         row_ff    <= '0;
         b_v_ff    <= 1'b0;
         fv_ff     <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         state_ff  <= state_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         b_v_ff    <= b_v_in;
         fv_ff     <= fv_in;
         out_v_ff  <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      b_e_ff       <= b_e_in;
      b_col_ff     <= b_col_in;
      b_row_ff     <= b_row_in;
      lft_ff       <= lft_in;
      ctr_ff       <= ctr_in;
      scan_ff      <= scan_in;
      fcol_ff      <= fcol_in;
      best_cost_ff <= best_cost_in;
      best_col_ff  <= best_col_in;
      bk_row_ff    <= bk_row_in;
      bk_col_ff    <= bk_col_in;
      bl_ff        <= bl_in;
      bc_ff        <= bc_in;
      em_row_ff    <= em_row_in;
      out_row_ff   <= out_row_in;
      out_col_ff   <= out_col_in;
      out_last_ff  <= out_last_in;
   end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 100ps
// testbench for seam_carving_min_seam_finder: directed table then random frames, checked
// against an in-bench seam predictor. depends on smsf_pkg, smsf_req_if, smsf_rsp_if and the rtl
module testbench;
   import smsf_pkg::*;

   localparam int MAX_COLS    = 256;
   localparam int MAX_ROWS    = 64;
   localparam int HOLD_CYCLES = 300;
   localparam int RANDOM_PIXELS = 70;

   typedef enum {STEP_WIDTH, STEP_HEIGHT, STEP_PIXEL} step_kind_type;
   typedef enum {FILL_UNIFORM, FILL_EXTREME, FILL_MAX, FILL_RIGHT_EDGE} fill_kind_type;

   typedef struct {
      step_kind_type    kind;
      logic [8:0]       value;
      bit               typed;
      logic [COL_W-1:0] typed_col;
   } step_row_type;

   typedef struct packed {
      logic [ROW_W-1:0] seam_row;
      logic [COL_W-1:0] seam_column;
      logic             seam_last;
   } seam_entry_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   csr_index_type         csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   smsf_req_if req_ch ();
   smsf_rsp_if rsp_ch ();

   seam_carving_min_seam_finder #(.MAX_WIDTH(MAX_COLS), .MAX_HEIGHT(MAX_ROWS)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor state
   logic [COST_W-1:0]       cost_map [0:MAX_ROWS-1][0:MAX_COLS-1];
   int                      seam_path [0:MAX_ROWS-1];
   logic [WIDTH_CFG_W-1:0]  width_cfg;
   logic [HEIGHT_CFG_W-1:0] height_cfg;
   int                      row_pos;
   int                      col_pos;

   seam_entry_type seam_expected [$];
   int             mismatches;
   int             pixels_sent;
   bit             random_part;
   bit             quiet;

   step_row_type steps [37] = '{
      '{STEP_WIDTH,  9'd3,   0, 8'd0},
      '{STEP_HEIGHT, 9'd1,   0, 8'd0},
      '{STEP_PIXEL,  9'd9,   0, 8'd0},
      '{STEP_PIXEL,  9'd4,   0, 8'd0},
      '{STEP_PIXEL,  9'd4,   1, 8'd1},
      '{STEP_WIDTH,  9'd0,   0, 8'd0},
      '{STEP_HEIGHT, 9'd0,   0, 8'd0},
      '{STEP_PIXEL,  9'd255, 1, 8'd0},
      '{STEP_WIDTH,  9'd2,   0, 8'd0},
      '{STEP_HEIGHT, 9'd2,   0, 8'd0},
      '{STEP_PIXEL,  9'd0,   0, 8'd0},
      '{STEP_PIXEL,  9'd255, 0, 8'd0},
      '{STEP_PIXEL,  9'd255, 0, 8'd0},
      '{STEP_PIXEL,  9'd0,   0, 8'd0},
      '{STEP_WIDTH,  9'd3,   0, 8'd0},
      '{STEP_HEIGHT, 9'd3,   0, 8'd0},
      '{STEP_PIXEL,  9'd9,   0, 8'd0},
      '{STEP_PIXEL,  9'd9,   0, 8'd0},
      '{STEP_PIXEL,  9'd1,   0, 8'd0},
      '{STEP_PIXEL,  9'd9,   0, 8'd0},
      '{STEP_PIXEL,  9'd9,   0, 8'd0},
      '{STEP_PIXEL,  9'd9,   0, 8'd0},
      '{STEP_PIXEL,  9'd9,   0, 8'd0},
      '{STEP_PIXEL,  9'd1,   0, 8'd0},
      '{STEP_PIXEL,  9'd9,   0, 8'd0},
      '{STEP_WIDTH,  9'd4,   0, 8'd0},
      '{STEP_HEIGHT, 9'd1,   0, 8'd0},
      '{STEP_PIXEL,  9'd255, 0, 8'd0},
      '{STEP_PIXEL,  9'd255, 0, 8'd0},
      '{STEP_PIXEL,  9'd0,   0, 8'd0},
      '{STEP_PIXEL,  9'd0,   1, 8'd2},
      '{STEP_HEIGHT, 9'd2,   0, 8'd0},
      '{STEP_PIXEL,  9'd1,   0, 8'd0},
      '{STEP_PIXEL,  9'd2,   0, 8'd0},
      '{STEP_WIDTH,  9'd1,   0, 8'd0},
      '{STEP_PIXEL,  9'd5,   0, 8'd0},
      '{STEP_PIXEL,  9'd6,   0, 8'd0}
   };

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   function automatic int eff_width();
      if (width_cfg == 0) return 1;
      if (width_cfg > MAX_COLS) return MAX_COLS;
      return width_cfg;
   endfunction

   function automatic int eff_height();
      if (height_cfg == 0) return 1;
      if (height_cfg > MAX_ROWS) return MAX_ROWS;
      return height_cfg;
   endfunction

   // cheapest of the up to three costs in row y around x: left, then center, then right
   function automatic int cheapest_above(int y, int x, int w);
      int                pick;
      logic [COST_W-1:0] val;
      pick = x;
      val  = cost_map[y][x];
      if (x > 0 && cost_map[y][x-1] <= val) begin
         pick = x - 1;
         val  = cost_map[y][x-1];
      end
      if (x + 1 < w && cost_map[y][x+1] < val) pick = x + 1;
      return pick;
   endfunction

   // accumulate one pixel; returns the seam length when the frame closes, else 0
   function automatic int trace_pixel(logic [ENERGY_W-1:0] e);
      int          w;
      int          h;
      int          x;
      int          y;
      int          c;
      int          i;
      int unsigned cost;
      w = eff_width();
      h = eff_height();
      x = col_pos;
      y = row_pos;
      if (x >= w || y >= h) begin
         x = 0;
         y = 0;
      end
      cost = e;
      if (y > 0) cost = e + cost_map[y-1][cheapest_above(y - 1, x, w)];
      cost_map[y][x] = COST_W'(cost);
      x++;
      if (x < w) begin
         col_pos = x;
         row_pos = y;
         return 0;
      end
      col_pos = 0;
      if (y + 1 < h) begin
         row_pos = y + 1;
         return 0;
      end
      row_pos = 0;
      c = 0;
      for (i = 1; i < w; i++) begin
         if (cost_map[h-1][i] < cost_map[h-1][c]) c = i;
      end
      seam_path[h-1] = c;
      for (i = h - 1; i > 0; i--) begin
         c = cheapest_above(i - 1, c, w);
         seam_path[i-1] = c;
      end
      return h;
   endfunction

   function automatic logic [ENERGY_W-1:0] make_energy(fill_kind_type fill, int col, int w);
      case (fill)
         FILL_MAX: return 8'hFF;
         FILL_RIGHT_EDGE: return (col == w - 1) ? 8'h00 : 8'hFF;
         FILL_EXTREME: begin
            case ($urandom_range(0, 2))
               0: return 8'h00;
               1: return 8'hFF;
               default: return 8'($urandom_range(0, 255));
            endcase
         end
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic void note_mismatch(string field, logic [31:0] want, logic [31:0] got);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch on %s: expected %0d, got %0d", field, want, got);
   endfunction

   task automatic send_pixel(input logic [ENERGY_W-1:0] e, input bit typed = 0,
                             input logic [COL_W-1:0] typed_col = '0);
      int             n;
      int             r;
      seam_entry_type entry;
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_ch.valid  <= 1'b1;
      req_ch.energy <= e;
      do @(posedge clock); while (!req_ch.ready);
      pixels_sent++;
      n = trace_pixel(e);
      if (typed) begin
         entry.seam_row    = '0;
         entry.seam_column = typed_col;
         entry.seam_last   = 1'b1;
         seam_expected.push_back(entry);
      end else begin
         for (r = 0; r < n; r++) begin
            entry.seam_row    = ROW_W'(r);
            entry.seam_column = COL_W'(seam_path[r]);
            entry.seam_last   = (r == n - 1);
            seam_expected.push_back(entry);
         end
      end
   endtask

   // wait for all seams, then let a partial frame finish its writes
   task automatic drain_pipeline();
      req_ch.valid <= 1'b0;
      while (seam_expected.size() != 0) @(posedge clock);
      repeat (eff_width() + 5 * eff_height() + 20) @(posedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      drain_pipeline();
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == REG_IMAGE_WIDTH) width_cfg = data;
      else height_cfg = data[HEIGHT_CFG_W-1:0];
      col_pos = 0;
      row_pos = 0;
   endtask

   task automatic run_phase(input int w, input int h, input int frames, input bit partial,
                            input fill_kind_type fill);
      int wv;
      int hv;
      int f;
      int r;
      int c;
      wv = w;
      hv = h;
      if (w == 1 && $urandom_range(0, 1)) wv = 0;
      if (w == MAX_COLS && $urandom_range(0, 1)) wv = $urandom_range(MAX_COLS + 1, 511);
      if (h == 1 && $urandom_range(0, 1)) hv = 0;
      if (h == MAX_ROWS && $urandom_range(0, 1)) hv = $urandom_range(MAX_ROWS + 1, 127);
      write_register(REG_IMAGE_WIDTH, CSR_DATA_W'(wv));
      write_register(REG_IMAGE_HEIGHT, {2'($urandom_range(0, 3)), 7'(hv)});
      for (f = 0; f < frames; f++) begin
         for (r = 0; r < h; r++) begin
            for (c = 0; c < w; c++) send_pixel(make_energy(fill, c, w));
         end
      end
      // abandoned frame, restarted by the next register write
      if (partial && w * h > 1) begin
         repeat ($urandom_range(1, w * h - 1)) send_pixel(make_energy(fill, 0, w));
      end
   endtask

   // result side: random stalls, one long hold-off while the sender is busy
   initial begin
      int             stall_left;
      bit             hold_pending;
      seam_entry_type want;
      rsp_ch.ready = 1'b0;
      stall_left   = 0;
      hold_pending = 1'b1;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            if (seam_expected.size() == 0) begin
               note_mismatch("unexpected seam row", 32'hFFFF_FFFF, rsp_ch.seam_row);
            end else begin
               want = seam_expected.pop_front();
               if (rsp_ch.seam_row !== want.seam_row)
                  note_mismatch("seam_row", want.seam_row, rsp_ch.seam_row);
               if (rsp_ch.seam_column !== want.seam_column)
                  note_mismatch("seam_column", want.seam_column, rsp_ch.seam_column);
               if (rsp_ch.seam_last !== want.seam_last)
                  note_mismatch("seam_last", want.seam_last, rsp_ch.seam_last);
            end
            if (hold_pending && random_part && req_ch.valid) begin
               hold_pending = 1'b0;
               stall_left   = HOLD_CYCLES;
            end
         end
         if (stall_left > 0) stall_left--;
         else if (!quiet && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 6);
         rsp_ch.ready <= (stall_left == 0);
      end
   end

   initial begin
      int i;
      reset         = 1'b1;
      csr_wr_en     = 1'b0;
      csr_index     = REG_IMAGE_WIDTH;
      csr_wdata     = '0;
      req_ch.valid  = 1'b0;
      req_ch.energy = '0;
      width_cfg     = WIDTH_RESET;
      height_cfg    = HEIGHT_RESET;
      row_pos       = 0;
      col_pos       = 0;
      mismatches    = 0;
      pixels_sent   = 0;
      random_part   = 1'b0;
      quiet         = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (i = 0; i < $size(steps); i++) begin
         case (steps[i].kind)
            STEP_WIDTH: write_register(REG_IMAGE_WIDTH, steps[i].value);
            STEP_HEIGHT: write_register(REG_IMAGE_HEIGHT, steps[i].value);
            default: send_pixel(steps[i].value[7:0], steps[i].typed, steps[i].typed_col);
         endcase
      end

      random_part = 1'b1;
      // several frames back to back so the sender is busy during the long hold-off
      run_phase(3, 3, 3, 0, FILL_RIGHT_EDGE);
      while (pixels_sent < $size(steps) + RANDOM_PIXELS) begin
         run_phase($urandom_range(1, 8), $urandom_range(1, 6), $urandom_range(1, 3),
                   $urandom_range(0, 2) == 0,
                   ($urandom_range(0, 3) == 0) ? FILL_EXTREME : FILL_UNIFORM);
      end
      run_phase(1, MAX_ROWS, 1, 0, FILL_MAX);

      quiet = 1'b1;
      run_phase(4, 5, 1, 0, FILL_UNIFORM);
      drain_pipeline();

      if (mismatches == 0 && seam_expected.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule

FILE: sim.f
hdl/smsf_pkg.sv
hdl/smsf_req_if.sv
hdl/smsf_rsp_if.sv
hdl/smsf_cost_ram.sv
hdl/seam_carving_min_seam_finder.sv
bench/testbench.sv
